// ===== hw/rtl/active_fault_recency_list_top_macros.svh =====
// Assertion helpers for the fault recency list top level.
// Each helper expects clk and arst_n to be visible where it is used.
`ifndef ACTIVE_FAULT_RECENCY_LIST_TOP_MACROS_SVH
`define ACTIVE_FAULT_RECENCY_LIST_TOP_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define AFRL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication.
`define AFRL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AFRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/afrl_pkg.sv =====
package afrl_pkg;

	localparam int unsigned ID_W              = 5;
	localparam int unsigned CMD_W             = 2;
	localparam int unsigned JIX_W             = 4;
	localparam int unsigned DEF_NUM_FAULTS    = 32;
	localparam int unsigned DEF_JOURNAL_DEPTH = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_QUERY = 2'd3
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic bypass;
		logic link;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic link_op;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/afrl_ctrl.sv =====
module afrl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  afrl_pkg::dp_sts_t sts,
	output afrl_pkg::dp_cmd_t ctl
);
	import afrl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_BYP,
		ST_LNK,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DEC;
				end
				ST_DEC: begin
					// skip the link passes when no list entry moves
					state_q <= sts.link_op ? ST_BYP : ST_FIN;
				end
				ST_BYP: begin
					state_q <= ST_LNK;
				end
				ST_LNK: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ctl          = '0;
		ctl.capture  = in_ready && in_valid;
		ctl.decode   = (state_q == ST_DEC);
		ctl.bypass   = (state_q == ST_BYP);
		ctl.link     = (state_q == ST_LNK);
		ctl.load_out = (state_q == ST_FIN) && sts.out_free;
	end

endmodule

// ===== hw/rtl/afrl_dp.sv =====
module afrl_dp #(
	parameter int unsigned NUM_FAULTS    = afrl_pkg::DEF_NUM_FAULTS,
	parameter int unsigned JOURNAL_DEPTH = afrl_pkg::DEF_JOURNAL_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  afrl_pkg::dp_cmd_t           ctl,
	output afrl_pkg::dp_sts_t           sts,
	input  logic [afrl_pkg::CMD_W-1:0]  cmd,
	input  logic [afrl_pkg::ID_W-1:0]   error_id,
	input  logic [afrl_pkg::JIX_W-1:0]  journal_index,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [afrl_pkg::ID_W-1:0]   top_error,
	output logic                        queried_active,
	output logic [afrl_pkg::ID_W-1:0]   journal_entry
);
	import afrl_pkg::*;

	localparam int unsigned AW = $clog2(NUM_FAULTS);
	localparam int unsigned JW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;

	function automatic logic [AW-1:0] to_aidx(input logic [ID_W-1:0] v);
		logic [AW+ID_W-1:0] w;
		w = {{AW{1'b0}}, v};
		return w[AW-1:0];
	endfunction

	function automatic logic [JW-1:0] to_jidx(input logic [JIX_W-1:0] v);
		logic [JW+JIX_W-1:0] w;
		w = {{JW{1'b0}}, v};
		return w[JW-1:0];
	endfunction

	// request held for the whole operation
	op_t               cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [JIX_W-1:0]  jix_q;

	// link tables: values only meaningful while the matching valid bit is set
	logic [ID_W-1:0]   up_mem   [NUM_FAULTS];
	logic [ID_W-1:0]   down_mem [NUM_FAULTS];
	logic [ID_W-1:0]   up_rd_q;
	logic [ID_W-1:0]   down_rd_q;

	logic [NUM_FAULTS-1:0] upv_q;
	logic [NUM_FAULTS-1:0] downv_q;
	logic [ID_W-1:0]       top_q;
	logic [ID_W-1:0]       jrnl_q [JOURNAL_DEPTH];

	logic              out_valid_q;
	logic [ID_W-1:0]   top_error_q;
	logic              queried_q;
	logic [ID_W-1:0]   journal_entry_q;

	logic              in_table;
	logic              act_ok;
	logic              push_ok;
	logic              pop_ok;
	logic              id_upv;
	logic              id_downv;
	logic              jix_ok;
	logic [AW-1:0]     id_idx;
	logic [AW-1:0]     up_idx;
	logic [AW-1:0]     down_idx;
	logic [AW-1:0]     top_idx;
	logic [JW-1:0]     jidx;

	always_comb begin
		id_idx   = to_aidx(id_q);
		up_idx   = to_aidx(up_rd_q);
		down_idx = to_aidx(down_rd_q);
		top_idx  = to_aidx(top_q);
		jidx     = to_jidx(jix_q);
		in_table = 32'(id_q) < NUM_FAULTS;
		act_ok   = in_table && (id_q != '0);
		push_ok  = (cmd_q == CMD_PUSH) && act_ok;
		pop_ok   = (cmd_q == CMD_POP) && act_ok;
		id_upv   = in_table ? upv_q[id_idx] : 1'b0;
		id_downv = in_table ? downv_q[id_idx] : 1'b0;
		jix_ok   = 32'(jix_q) < JOURNAL_DEPTH;

		sts.link_op  = (push_ok && (top_q != id_q)) || (pop_ok && (id_upv || id_downv));
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= op_t'(cmd);
			id_q  <= error_id;
			jix_q <= journal_index;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			up_rd_q   <= up_mem[id_idx];
			down_rd_q <= down_mem[id_idx];
		end
		if (ctl.bypass) begin
			// splice the entry out of its neighbours
			if (id_upv)   down_mem[up_idx] <= down_rd_q;
			if (id_downv) up_mem[down_idx] <= up_rd_q;
		end
		if (ctl.link && push_ok) begin
			up_mem[top_idx]  <= id_q;
			down_mem[id_idx] <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upv_q       <= '0;
			downv_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < JOURNAL_DEPTH; i++) jrnl_q[i] <= '0;
		end else begin
			if (ctl.decode) begin
				if (cmd_q == CMD_CLEAR) begin
					upv_q   <= '0;
					downv_q <= '0;
					top_q   <= '0;
				end
				// journal every push, even of the current top
				if (push_ok) begin
					for (int i = 1; i < JOURNAL_DEPTH; i++) jrnl_q[i] <= jrnl_q[i-1];
					jrnl_q[0] <= id_q;
				end
			end
			if (ctl.bypass) begin
				if (id_upv)   downv_q[up_idx] <= id_downv;
				if (id_downv) upv_q[down_idx] <= id_upv;
				// popping the top hands the top to the entry below, or the sentinel
				if (pop_ok && !id_upv) top_q <= id_downv ? down_rd_q : '0;
			end
			if (ctl.link) begin
				if (push_ok) begin
					upv_q[top_idx]  <= 1'b1;
					upv_q[id_idx]   <= 1'b0;
					downv_q[id_idx] <= 1'b1;
					top_q           <= id_q;
				end else begin
					upv_q[id_idx]   <= 1'b0;
					downv_q[id_idx] <= 1'b0;
				end
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			top_error_q     <= top_q;
			queried_q       <= id_upv || id_downv;
			journal_entry_q <= jix_ok ? jrnl_q[jidx] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign top_error      = top_error_q;
	assign queried_active = queried_q;
	assign journal_entry  = journal_entry_q;

endmodule

// ===== hw/rtl/active_fault_recency_list_top.sv =====
// Active fault recency list: keeps active faults as a most-recent-first doubly linked list
// over a table of NUM_FAULTS ids (id 0 is the bottom sentinel) and journals every push of
// a real fault in a JOURNAL_DEPTH-deep shift register, newest at index 0. Each request
// (push, pop, clear, query) returns one result: the top fault, whether the named fault is
// linked, and the journal entry at the requested index, all after the update. The result
// is loaded into the output register after the decode step when no list entry moves (query,
// clear, push of the current top, pop of an unlinked fault, id 0 or ids out of range) and
// after decode, splice and relink steps when links change; splice and relink are separate
// steps as each link table has a single write port and a registered read. One request is in
// flight at a time; the next one is taken the cycle after the result is loaded. A new
// request is taken while the previous result still waits in the output register, and a
// result waits there until it is taken.
module active_fault_recency_list_top #(
	parameter int unsigned NUM_FAULTS    = afrl_pkg::DEF_NUM_FAULTS,
	parameter int unsigned JOURNAL_DEPTH = afrl_pkg::DEF_JOURNAL_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [afrl_pkg::CMD_W-1:0]  cmd,
	input  logic [afrl_pkg::ID_W-1:0]   error_id,
	input  logic [afrl_pkg::JIX_W-1:0]  journal_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [afrl_pkg::ID_W-1:0]   top_error,
	output logic                        queried_active,
	output logic [afrl_pkg::ID_W-1:0]   journal_entry
);
	import afrl_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	afrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	afrl_dp #(
		.NUM_FAULTS    (NUM_FAULTS),
		.JOURNAL_DEPTH (JOURNAL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.error_id       (error_id),
		.journal_index  (journal_index),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.top_error      (top_error),
		.queried_active (queried_active),
		.journal_entry  (journal_entry)
	);

`include "active_fault_recency_list_top_macros.svh"

	`AFRL_ASSERT_ALWAYS(a_ctl_onehot, $onehot0(ctl), "more than one datapath step at once")
	`AFRL_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken early")
	`AFRL_ASSERT_NEXT(a_bypass_then_link, ctl.bypass, ctl.link, "splice not followed by relink")
	`AFRL_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import afrl_pkg::*;

	localparam int unsigned FAULTS = DEF_NUM_FAULTS;
	localparam int unsigned DEPTH  = DEF_JOURNAL_DEPTH;
	localparam int unsigned RANDOM_REQUESTS = 1750;

	typedef struct packed {
		logic [ID_W-1:0] top;
		logic            active;
		logic [ID_W-1:0] entry;
	} fault_view_t;

	class fault_list_scoreboard;
		logic [ID_W-1:0] up_to[FAULTS];
		logic [ID_W-1:0] dn_to[FAULTS];
		bit              up_ok[FAULTS];
		bit              dn_ok[FAULTS];
		logic [ID_W-1:0] top;
		logic [ID_W-1:0] journal[DEPTH];
		fault_view_t     expected[$];
		int              errors;
		int              checked;
		int              op_count[4];
		int              deepest;

		function new();
			empty_list();
			foreach (journal[i])
				journal[i] = '0;
			errors = 0;
			checked = 0;
			deepest = 0;
			foreach (op_count[i])
				op_count[i] = 0;
		endfunction

		function void empty_list();
			foreach (up_to[i]) begin
				up_to[i] = '0;
				dn_to[i] = '0;
				up_ok[i] = 0;
				dn_ok[i] = 0;
			end
			top = '0;
		endfunction

		// Join the neighbours of n to each other; n keeps its own links.
		function void splice_out(int unsigned n);
			int unsigned u;
			int unsigned d;
			if (up_ok[n]) begin
				u = up_to[n];
				dn_to[u] = dn_to[n];
				dn_ok[u] = dn_ok[n];
			end
			if (dn_ok[n]) begin
				d = dn_to[n];
				up_to[d] = up_to[n];
				up_ok[d] = up_ok[n];
			end
		endfunction

		function void raise_fault(int unsigned id);
			int unsigned t;
			for (int i = DEPTH - 1; i > 0; i--)
				journal[i] = journal[i-1];
			journal[0] = ID_W'(id);
			if (top == id)
				return;
			splice_out(id);
			t = top;
			up_to[t] = ID_W'(id);
			up_ok[t] = 1;
			up_to[id] = '0;
			up_ok[id] = 0;
			dn_to[id] = ID_W'(t);
			dn_ok[id] = 1;
			top = ID_W'(id);
		endfunction

		function void resolve_fault(int unsigned id);
			if (!up_ok[id] && !dn_ok[id])
				return;
			if (!up_ok[id])
				top = dn_ok[id] ? dn_to[id] : '0;
			splice_out(id);
			up_to[id] = '0;
			up_ok[id] = 0;
			dn_to[id] = '0;
			dn_ok[id] = 0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
				logic [JIX_W-1:0] jix);
			fault_view_t view;
			int          linked;
			op_count[cmd]++;
			unique case (op_t'(cmd))
				CMD_PUSH: if (id != 0) raise_fault(id);
				CMD_POP: if (id != 0) resolve_fault(id);
				CMD_CLEAR: empty_list();
				default: ;
			endcase
			view.top = top;
			view.active = up_ok[id] || dn_ok[id];
			view.entry = journal[jix];
			expected.push_back(view);
			linked = 0;
			for (int i = 1; i < FAULTS; i++)
				if (dn_ok[i])
					linked++;
			if (linked > deepest)
				deepest = linked;
		endfunction

		function void check_result(logic [ID_W-1:0] top_error, logic queried_active,
				logic [ID_W-1:0] journal_entry);
			fault_view_t want;
			if (expected.size() == 0) begin
				$error("result with nothing outstanding: top_error=%0d", top_error);
				errors++;
				return;
			end
			want = expected.pop_front();
			checked++;
			if (top_error !== want.top) begin
				$error("top_error: expected %0d, got %0d", want.top, top_error);
				errors++;
			end
			if (queried_active !== want.active) begin
				$error("queried_active: expected %0d, got %0d", want.active,
					queried_active);
				errors++;
			end
			if (journal_entry !== want.entry) begin
				$error("journal_entry: expected %0d, got %0d", want.entry, journal_entry);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             in_valid = 0;
	logic             in_ready;
	logic [CMD_W-1:0] cmd = '0;
	logic [ID_W-1:0]  error_id = '0;
	logic [JIX_W-1:0] journal_index = '0;
	logic             out_valid;
	logic             out_ready = 0;
	logic [ID_W-1:0]  top_error;
	logic             queried_active;
	logic [ID_W-1:0]  journal_entry;
	bit               no_idle = 0;

	fault_list_scoreboard sb = new();

	active_fault_recency_list_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.error_id(error_id),
		.journal_index(journal_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_error(top_error),
		.queried_active(queried_active),
		.journal_entry(journal_entry)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(cmd, error_id, journal_index);
			if (out_valid && out_ready)
				sb.check_result(top_error, queried_active, journal_entry);
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_request(input op_t op, input logic [ID_W-1:0] id,
			input logic [JIX_W-1:0] jix);
		int gap;
		in_valid <= 1'b1;
		cmd <= op;
		error_id <= id;
		journal_index <= jix;
		do
			@(posedge clk);
		while (!in_ready);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, with a stall-free stretch when no_idle is set
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_len();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		op_t             op;
		logic [ID_W-1:0] id;
		int              r;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// sentinel and basic relinking
		send_request(CMD_QUERY, 5'd0, 4'd0);
		send_request(CMD_PUSH, 5'd0, 4'd0);
		send_request(CMD_POP, 5'd0, 4'd0);
		send_request(CMD_PUSH, 5'd31, 4'd15);
		send_request(CMD_PUSH, 5'd1, 4'd0);
		send_request(CMD_PUSH, 5'd1, 4'd1);
		send_request(CMD_PUSH, 5'd16, 4'd2);
		send_request(CMD_PUSH, 5'd31, 4'd3);
		send_request(CMD_QUERY, 5'd0, 4'd4);
		send_request(CMD_POP, 5'd1, 4'd1);
		send_request(CMD_POP, 5'd7, 4'd0);
		send_request(CMD_POP, 5'd31, 4'd2);
		send_request(CMD_POP, 5'd16, 4'd15);
		send_request(CMD_QUERY, 5'd0, 4'd15);
		send_request(CMD_PUSH, 5'd21, 4'd10);
		send_request(CMD_PUSH, 5'd10, 4'd5);
		send_request(CMD_CLEAR, 5'd10, 4'd0);
		// the sentinel must not keep its up link across a clear
		send_request(CMD_QUERY, 5'd0, 4'd4);
		send_request(CMD_QUERY, 5'd21, 4'd1);
		send_request(CMD_PUSH, 5'd10, 4'd0);
		send_request(CMD_POP, 5'd10, 4'd1);
		send_request(CMD_PUSH, 5'd30, 4'd15);
		send_request(CMD_PUSH, 5'd15, 4'd14);
		send_request(CMD_QUERY, 5'd31, 4'd9);

		// hold off until every result is back
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			no_idle = (n >= 600 && n < 900);
			if (n == 1200) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			r = $urandom_range(0, 99);
			id = ID_W'($urandom_range(0, 31));
			if (r < 50) begin
				op = CMD_PUSH;
			end else if (r < 80) begin
				op = CMD_POP;
				// often drop whatever is on top
				if ($urandom_range(0, 3) == 0)
					id = sb.top;
			end else if (r < 83) begin
				op = CMD_CLEAR;
			end else begin
				op = CMD_QUERY;
			end
			send_request(op, id, JIX_W'($urandom_range(0, 15)));
		end
		no_idle = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Checked %0d results: %0d push, %0d pop, %0d clear, %0d query requests",
			sb.checked, sb.op_count[CMD_PUSH], sb.op_count[CMD_POP],
			sb.op_count[CMD_CLEAR], sb.op_count[CMD_QUERY]);
		$display("Deepest fault list reached: %0d linked faults", sb.deepest);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
